// ===== design/separable_gaussian_blur_core_macros.svh =====
// Assertion macros for the bound checker.
`ifndef SEPARABLE_GAUSSIAN_BLUR_CORE_MACROS_SVH
`define SEPARABLE_GAUSSIAN_BLUR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SGB_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("sgb assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SGB_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("sgb assertion failed");

`endif

// ===== design/sgb_pkg.sv =====
package sgb_pkg;

    localparam int DEF_MAX_RADIUS   = 7;
    localparam int DEF_MAX_WIDTH    = 1024;
    localparam int DEF_MAX_CHANNELS = 4;
    localparam int SAMPLE_W         = 16;
    localparam int CFG_W            = 64;
    localparam int TAP_COUNT        = 16;

    localparam logic [2:0] CFG_RADIUS   = 3'd0;
    localparam logic [2:0] CFG_WIDTH    = 3'd1;
    localparam logic [2:0] CFG_HEIGHT   = 3'd2;
    localparam logic [2:0] CFG_CHANNELS = 3'd3;
    localparam logic [2:0] CFG_TAPS0    = 3'd4;
    localparam logic [2:0] CFG_TAPS1    = 3'd5;
    localparam logic [2:0] CFG_TAPS2    = 3'd6;
    localparam logic [2:0] CFG_TAPS3    = 3'd7;

    localparam logic CMD_SAMPLE = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_VINIT,
        S_HINIT,
        S_RD,
        S_MUL,
        S_HACC,
        S_HFIN,
        S_VMUL,
        S_VACC,
        S_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic vinit;
        logic hinit;
        logic rd;
        logic mul;
        logic hacc;
        logic hfin;
        logic vmul;
        logic vacc;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic ready;
        logic h_last;
        logic v_last;
        logic out_free;
    } t_status;

    function automatic logic [SAMPLE_W-1:0] tap_weight(
        input logic [TAP_COUNT*SAMPLE_W-1:0] taps,
        input logic [3:0]                    idx
    );
        return taps[idx*SAMPLE_W +: SAMPLE_W];
    endfunction

    // Add one half, drop 15 fraction bits, saturate to 16 bits.
    function automatic logic [SAMPLE_W-1:0] round_sat(input logic [47:0] acc);
        logic [47:0] sum;
        sum = acc + 48'd16384;
        if (|sum[47:31]) begin
            return 16'hFFFF;
        end
        return sum[30:15];
    endfunction

endpackage

// ===== design/sgb_ctrl.sv =====
module sgb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  sgb_pkg::t_status i_st,
    output sgb_pkg::t_cmd    o_cmd
);
    import sgb_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_CHECK;
            S_CHECK: n_state = i_st.ready ? S_VINIT : S_IDLE;
            S_VINIT: n_state = S_HINIT;
            S_HINIT: n_state = S_RD;
            S_RD:    n_state = S_MUL;
            S_MUL:   n_state = S_HACC;
            S_HACC:  n_state = i_st.h_last ? S_HFIN : S_RD;
            S_HFIN:  n_state = S_VMUL;
            S_VMUL:  n_state = S_VACC;
            S_VACC:  n_state = i_st.v_last ? S_OUT : S_HINIT;
            S_OUT:   if (i_st.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_VINIT: o_cmd.vinit = 1'b1;
            S_HINIT: o_cmd.hinit = 1'b1;
            S_RD:    o_cmd.rd    = 1'b1;
            S_MUL:   o_cmd.mul   = 1'b1;
            S_HACC:  o_cmd.hacc  = 1'b1;
            S_HFIN:  o_cmd.hfin  = 1'b1;
            S_VMUL:  o_cmd.vmul  = 1'b1;
            S_VACC:  o_cmd.vacc  = 1'b1;
            S_OUT:   o_cmd.load  = i_st.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== design/sgb_dp.sv =====
module sgb_dp #(
    parameter int MAX_RADIUS   = sgb_pkg::DEF_MAX_RADIUS,
    parameter int MAX_WIDTH    = sgb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = sgb_pkg::DEF_MAX_CHANNELS,
    localparam int RW = $clog2(MAX_RADIUS + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sgb_pkg::t_cmd         i_cmd,
    output sgb_pkg::t_status      o_st,
    input  logic [RW-1:0]         i_eff_r,
    input  logic [10:0]           i_eff_w,
    input  logic [12:0]           i_eff_h,
    input  logic [2:0]            i_eff_c,
    input  logic [255:0]          i_taps,
    input  logic                  i_restart,
    input  logic                  i_command,
    input  logic [15:0]           i_sample,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [15:0]           o_blurred_sample,
    output logic                  o_last_of_frame
);
    import sgb_pkg::*;

    localparam int TW    = RW + 1;
    localparam int RING  = 2 * MAX_RADIUS + 2;
    localparam int SB    = $clog2(RING);
    localparam int CB    = $clog2(MAX_WIDTH);
    localparam int CHB   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int AB    = SB + CB + CHB;
    localparam int DEPTH = 1 << AB;
    localparam int AW    = 32 + TW;

    logic [15:0] r_mem [0:DEPTH-1];

    logic [10:0]   r_icol, r_ocol, r_hcol;
    logic [12:0]   r_irow, r_orow;
    logic [1:0]    r_ich, r_och;
    logic [SB-1:0] r_islot, r_oslot, r_vslot;
    logic          r_done;
    logic [TW-1:0] r_t, r_u;
    logic [14:0]   r_vpos, n_vpos;
    logic [12:0]   r_hpos, n_hpos;
    logic [15:0]   r_rdata, r_hres;
    logic [31:0]   r_prod;
    logic [AW-1:0] r_hacc, r_vacc;
    logic          r_ovalid;
    logic [15:0]   r_odata;
    logic          r_olast;

    logic [10:0] w_m1;
    logic [12:0] h_m1;
    logic [11:0] nx;
    logic [13:0] ny;
    logic [TW-1:0] two_r;
    logic        wr_en;
    logic        is_last;
    logic [AB-1:0] wr_addr, rd_addr;

    assign w_m1  = i_eff_w - 11'd1;
    assign h_m1  = i_eff_h - 13'd1;
    assign two_r = {i_eff_r, 1'b0};
    assign nx = (12'(r_ocol) + 12'(i_eff_r) > 12'(w_m1)) ? 12'(w_m1)
              : 12'(r_ocol) + 12'(i_eff_r);
    assign ny = (14'(r_orow) + 14'(i_eff_r) > 14'(h_m1)) ? 14'(h_m1)
              : 14'(r_orow) + 14'(i_eff_r);

    always_comb begin
        o_st.ready = r_done
            || (ny < 14'(r_irow))
            || (ny == 14'(r_irow) && (nx < 12'(r_icol)
                || (nx == 12'(r_icol) && r_och < r_ich)));
        o_st.h_last   = (r_u == two_r);
        o_st.v_last   = (r_t == two_r);
        o_st.out_free = !r_ovalid || i_out_ready;
    end

    assign is_last = (r_ocol == w_m1) && (r_orow == h_m1) && (3'(r_och) == i_eff_c - 3'd1);
    assign wr_en   = i_cmd.accept && (i_command == CMD_SAMPLE) && !r_done;
    assign wr_addr = {r_islot, CB'(r_icol), CHB'(r_ich)};
    assign rd_addr = {r_vslot, CB'(r_hcol), CHB'(r_och)};
    assign n_vpos  = r_vpos + 15'd1;
    assign n_hpos  = r_hpos + 13'd1;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_sample;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Input position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart || (i_cmd.load && is_last)) begin
            r_icol  <= '0;
            r_irow  <= '0;
            r_ich   <= '0;
            r_islot <= '0;
            r_done  <= 1'b0;
        end else if (wr_en) begin
            if (3'(r_ich) + 3'd1 >= i_eff_c) begin
                r_ich <= '0;
                if (r_icol + 11'd1 >= i_eff_w) begin
                    r_icol <= '0;
                    if (r_irow + 13'd1 >= i_eff_h) begin
                        r_irow  <= '0;
                        r_islot <= '0;
                        r_done  <= 1'b1;
                    end else begin
                        r_irow  <= r_irow + 13'd1;
                        r_islot <= (int'(r_islot) == RING - 1) ? '0 : r_islot + SB'(1);
                    end
                end else begin
                    r_icol <= r_icol + 11'd1;
                end
            end else begin
                r_ich <= r_ich + 2'd1;
            end
        end
    end

    // Output position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart || (i_cmd.load && is_last)) begin
            r_ocol  <= '0;
            r_orow  <= '0;
            r_och   <= '0;
            r_oslot <= '0;
        end else if (i_cmd.load) begin
            if (3'(r_och) + 3'd1 >= i_eff_c) begin
                r_och <= '0;
                if (r_ocol + 11'd1 >= i_eff_w) begin
                    r_ocol  <= '0;
                    r_orow  <= r_orow + 13'd1;
                    r_oslot <= (int'(r_oslot) == RING - 1) ? '0 : r_oslot + SB'(1);
                end else begin
                    r_ocol <= r_ocol + 11'd1;
                end
            end else begin
                r_och <= r_och + 2'd1;
            end
        end
    end

    // Tap walkers and multiply-accumulate.
    always_ff @(posedge i_clk) begin
        if (i_cmd.vinit) begin
            r_t    <= '0;
            r_vacc <= '0;
            r_vpos <= 15'(r_orow) - 15'(i_eff_r);
            if (r_orow >= 13'(i_eff_r)) begin
                r_vslot <= (r_oslot >= SB'(i_eff_r)) ? r_oslot - SB'(i_eff_r)
                         : SB'(int'(r_oslot) + RING - int'(i_eff_r));
            end else begin
                r_vslot <= '0;
            end
        end
        if (i_cmd.hinit) begin
            r_u    <= '0;
            r_hacc <= '0;
            r_hpos <= 13'(r_ocol) - 13'(i_eff_r);
            r_hcol <= (r_ocol >= 11'(i_eff_r)) ? r_ocol - 11'(i_eff_r) : '0;
        end
        if (i_cmd.mul) begin
            r_prod <= 32'(r_rdata) * 32'(tap_weight(i_taps, 4'(r_u)));
        end
        if (i_cmd.hacc) begin
            r_hacc <= r_hacc + AW'(r_prod);
            r_u    <= r_u + TW'(1);
            r_hpos <= n_hpos;
            if (!n_hpos[12] && n_hpos != '0 && n_hpos <= 13'(w_m1)) begin
                r_hcol <= r_hcol + 11'd1;
            end
        end
        if (i_cmd.hfin) begin
            r_hres <= round_sat(48'(r_hacc));
        end
        if (i_cmd.vmul) begin
            r_prod <= 32'(r_hres) * 32'(tap_weight(i_taps, 4'(r_t)));
        end
        if (i_cmd.vacc) begin
            r_vacc <= r_vacc + AW'(r_prod);
            r_t    <= r_t + TW'(1);
            r_vpos <= n_vpos;
            if (!n_vpos[14] && n_vpos != '0 && n_vpos <= 15'(h_m1)) begin
                r_vslot <= (int'(r_vslot) == RING - 1) ? '0 : r_vslot + SB'(1);
            end
        end
        if (i_cmd.load) begin
            r_odata <= round_sat(48'(r_vacc));
            r_olast <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_out_valid      = r_ovalid;
    assign o_blurred_sample = r_odata;
    assign o_last_of_frame  = r_olast;

endmodule

// ===== design/separable_gaussian_blur_core.sv =====
// An input beat that frees an output walks every vertical and horizontal tap until the
// result is registered; one that frees none only passes the readiness check. No new beat
// is taken until the last one is done: all taps share one product register, and the line
// store gives one read per cycle. Reset is synchronous, active low; it restores the
// register defaults and clears the input and output positions, but not the line store.
//
// The block streams channel-interleaved samples into a ring of 2*MAX_RADIUS+2 row
// buffers. For each output it walks the vertical taps; for each vertical tap it walks the
// horizontal taps, reading one stored sample per step, clamping columns and rows to the
// frame edges. Each pass rounds to nearest and saturates to 16 bits.
// A result sits in an output register, so the next input beat is taken while it waits.
// A drain beat (command 1) only gives the next pending output a chance to leave.
module separable_gaussian_blur_core #(
    parameter int MAX_RADIUS   = sgb_pkg::DEF_MAX_RADIUS,
    parameter int MAX_WIDTH    = sgb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = sgb_pkg::DEF_MAX_CHANNELS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [15:0] i_sample,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_blurred_sample,
    output logic        o_last_of_frame,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import sgb_pkg::*;

    localparam int RW = $clog2(MAX_RADIUS + 1);

    logic [2:0]        r_radius;
    logic [10:0]       r_width;
    logic [12:0]       r_height;
    logic [2:0]        r_chan;
    logic [3:0][63:0]  r_taps;

    logic [RW-1:0] eff_r;
    logic [10:0]   eff_w;
    logic [12:0]   eff_h;
    logic [2:0]    eff_c;
    logic          geom_wr;
    t_cmd          cmd;
    t_status       st;

    // Configuration registers; geometry writes abandon the frame in progress.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 3'd0;
            r_width  <= 11'd1024;
            r_height <= 13'd1024;
            r_chan   <= 3'd1;
            r_taps   <= {64'd0, 64'd0, 64'd0, 64'd32768};
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RADIUS:   r_radius  <= i_cfg_data[2:0];
                CFG_WIDTH:    r_width   <= i_cfg_data[10:0];
                CFG_HEIGHT:   r_height  <= i_cfg_data[12:0];
                CFG_CHANNELS: r_chan    <= i_cfg_data[2:0];
                CFG_TAPS0:    r_taps[0] <= i_cfg_data;
                CFG_TAPS1:    r_taps[1] <= i_cfg_data;
                CFG_TAPS2:    r_taps[2] <= i_cfg_data;
                CFG_TAPS3:    r_taps[3] <= i_cfg_data;
                default:      r_chan    <= r_chan;
            endcase
        end
    end

    assign geom_wr = i_cfg_we && (i_cfg_index == CFG_RADIUS || i_cfg_index == CFG_WIDTH
                  || i_cfg_index == CFG_HEIGHT || i_cfg_index == CFG_CHANNELS);

    // Out-of-range geometry is pulled back to what the hardware supports.
    assign eff_r = (int'(r_radius) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(r_radius);
    assign eff_w = (r_width == 11'd0) ? 11'd1
                 : ((int'(r_width) > MAX_WIDTH) ? 11'(MAX_WIDTH) : r_width);
    assign eff_h = (r_height == 13'd0) ? 13'd1 : r_height;
    assign eff_c = (r_chan == 3'd0) ? 3'd1
                 : ((int'(r_chan) > MAX_CHANNELS) ? 3'(MAX_CHANNELS) : r_chan);

    sgb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    sgb_dp #(
        .MAX_RADIUS   (MAX_RADIUS),
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_st             (st),
        .i_eff_r          (eff_r),
        .i_eff_w          (eff_w),
        .i_eff_h          (eff_h),
        .i_eff_c          (eff_c),
        .i_taps           (r_taps),
        .i_restart        (geom_wr),
        .i_command        (i_command),
        .i_sample         (i_sample),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_blurred_sample (o_blurred_sample),
        .o_last_of_frame  (o_last_of_frame)
    );

endmodule

// ===== design/sgb_checker.sv =====
module sgb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [15:0] o_blurred_sample,
    input logic        o_last_of_frame
);
`include "separable_gaussian_blur_core_macros.svh"

    // A stalled result holds.
    `SGB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_blurred_sample) && $stable(o_last_of_frame))

    // An accepted beat always occupies the block for at least the next cycle.
    `SGB_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    // A new result is only produced while the block was busy with a beat.
    `SGB_ASSERT_IMPL(a_result_from_work, i_clk, i_rst_n, $rose(o_out_valid), $past(!o_in_ready))

endmodule

bind separable_gaussian_blur_core sgb_checker u_sgb_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_blurred_sample (o_blurred_sample),
    .o_last_of_frame  (o_last_of_frame)
);

// ===== sim/separable_gaussian_blur_checker.sv =====
`timescale 1ns / 100ps

// Watches the input, output and register channels of the blur core, keeps its own copy of
// the frame state, predicts every blurred sample and compares it with what leaves the core.
module separable_gaussian_blur_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_command,
    input  logic [15:0] i_sample,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_blurred_sample,
    input  logic        i_last_of_frame,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_outstanding,
    output int          o_predicted
);
    import sgb_pkg::*;

    localparam int MAXR   = DEF_MAX_RADIUS;
    localparam int MAXW   = DEF_MAX_WIDTH;
    localparam int MAXC   = DEF_MAX_CHANNELS;
    localparam int ROWS   = 2 * MAXR + 2;

    typedef struct {
        logic [15:0] value;
        logic        last;
    } blurred_t;

    logic [15:0] raw_rows [ROWS*MAXW*MAXC];
    blurred_t    pending_blurred [$];

    int unsigned radius_reg, width_reg, height_reg, chan_reg;
    logic [63:0] tap_words [4];
    int unsigned in_col, in_row, in_ch, out_col, out_row, out_ch;
    bit          frame_in;

    function automatic int unsigned radius_eff();
        return radius_reg > MAXR ? MAXR : radius_reg;
    endfunction

    function automatic int unsigned width_eff();
        int unsigned w;
        w = (width_reg == 0) ? 1 : width_reg;
        return w > MAXW ? MAXW : w;
    endfunction

    function automatic int unsigned height_eff();
        return height_reg == 0 ? 1 : height_reg;
    endfunction

    function automatic int unsigned chan_eff();
        int unsigned c;
        c = (chan_reg == 0) ? 1 : chan_reg;
        return c > MAXC ? MAXC : c;
    endfunction

    function automatic longint unsigned tap_at(int unsigned t);
        return (tap_words[t/4] >> ((t % 4) * 16)) & 64'hFFFF;
    endfunction

    function automatic logic [15:0] rnd_sat(longint unsigned acc);
        longint unsigned v;
        v = (acc + 16384) >> 15;
        return v > 65535 ? 16'hFFFF : v[15:0];
    endfunction

    function automatic int clamp_to(int v, int hi);
        return v < 0 ? 0 : (v > hi ? hi : v);
    endfunction

    function automatic logic [15:0] row_pass(int unsigned row, int unsigned x, int unsigned ch);
        longint unsigned acc;
        int unsigned     r, col;
        acc = 0;
        r = radius_eff();
        for (int unsigned t = 0; t <= 2 * r; t++) begin
            col = clamp_to(int'(x) + int'(t) - int'(r), int'(width_eff()) - 1);
            acc += tap_at(t) * raw_rows[((row % ROWS) * MAXW + col) * MAXC + ch];
        end
        return rnd_sat(acc);
    endfunction

    function automatic logic [15:0] blurred_at(int unsigned x, int unsigned y, int unsigned ch);
        longint unsigned acc;
        int unsigned     r, row;
        acc = 0;
        r = radius_eff();
        for (int unsigned t = 0; t <= 2 * r; t++) begin
            row = clamp_to(int'(y) + int'(t) - int'(r), int'(height_eff()) - 1);
            acc += tap_at(t) * row_pass(row, x, ch);
        end
        return rnd_sat(acc);
    endfunction

    function automatic bit next_ready();
        longint unsigned nx, ny, need, have, w, h, c;
        if (frame_in) begin
            return 1'b1;
        end
        w = width_eff();
        h = height_eff();
        c = chan_eff();
        nx = out_col + radius_eff();
        if (nx > w - 1) nx = w - 1;
        ny = out_row + radius_eff();
        if (ny > h - 1) ny = h - 1;
        need = (ny * w + nx) * c + out_ch;
        have = (longint'(in_row) * w + in_col) * c + in_ch;
        return need < have;
    endfunction

    task automatic restart_frame();
        in_col = 0; in_row = 0; in_ch = 0;
        out_col = 0; out_row = 0; out_ch = 0;
        frame_in = 1'b0;
    endtask

    // One input beat: store it if it is a sample of the open frame, then release the next output if it is ready.
    task automatic take_beat(logic cmd, logic [15:0] smp);
        blurred_t res;
        if (cmd == CMD_SAMPLE && !frame_in) begin
            raw_rows[((in_row % ROWS) * MAXW + in_col) * MAXC + in_ch] = smp;
            if (++in_ch >= chan_eff()) begin
                in_ch = 0;
                if (++in_col >= width_eff()) begin
                    in_col = 0;
                    if (++in_row >= height_eff()) begin
                        in_row = 0;
                        frame_in = 1'b1;
                    end
                end
            end
        end
        if (next_ready()) begin
            res.value = blurred_at(out_col, out_row, out_ch);
            res.last  = (out_col == width_eff() - 1) && (out_row == height_eff() - 1)
                        && (out_ch == chan_eff() - 1);
            pending_blurred.push_back(res);
            o_predicted++;
            if (res.last) begin
                restart_frame();
            end else if (++out_ch >= chan_eff()) begin
                out_ch = 0;
                if (++out_col >= width_eff()) begin
                    out_col = 0;
                    out_row++;
                end
            end
        end
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("checker: %s mismatch, got %0d want %0d at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_predicted  = 0;
        foreach (raw_rows[i]) raw_rows[i] = '0;
    end

    assign o_outstanding = pending_blurred.size();

    // Sampling at the falling edge sees every channel settled before the accepting edge.
    always @(negedge i_clk) begin
        blurred_t want;
        if (!i_rst_n) begin
            radius_reg = 0;
            width_reg  = 1024;
            height_reg = 1024;
            chan_reg   = 1;
            tap_words[0] = 64'd32768;
            tap_words[1] = '0;
            tap_words[2] = '0;
            tap_words[3] = '0;
            restart_frame();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_blurred.size() == 0) begin
                    report_mismatch("unexpected beat", i_blurred_sample, -1);
                end else begin
                    want = pending_blurred.pop_front();
                    if (i_blurred_sample !== want.value)
                        report_mismatch("blurred_sample", i_blurred_sample, want.value);
                    if (i_last_of_frame !== want.last)
                        report_mismatch("last_of_frame", i_last_of_frame, want.last);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_RADIUS: begin
                        radius_reg = i_cfg_data[2:0];
                        restart_frame();
                    end
                    CFG_WIDTH: begin
                        width_reg = i_cfg_data[10:0];
                        restart_frame();
                    end
                    CFG_HEIGHT: begin
                        height_reg = i_cfg_data[12:0];
                        restart_frame();
                    end
                    CFG_CHANNELS: begin
                        chan_reg = i_cfg_data[2:0];
                        restart_frame();
                    end
                    CFG_TAPS0: tap_words[0] = i_cfg_data;
                    CFG_TAPS1: tap_words[1] = i_cfg_data;
                    CFG_TAPS2: tap_words[2] = i_cfg_data;
                    CFG_TAPS3: tap_words[3] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                take_beat(i_command, i_sample);
            end
        end
    end

endmodule

// ===== sim/tb_separable_gaussian_blur_core.sv =====
`timescale 1ns / 100ps

// Top of the blur core testbench. It drives frames of samples and drain beats into the
// core, writes the geometry and tap registers between frames, and throttles the output
// side. All prediction and comparison lives in the checker instantiated beside the core.
module tb_separable_gaussian_blur_core;
    import sgb_pkg::*;

    localparam int  LIMIT_CYCLES   = 6000000;
    localparam int  RANDOM_SAMPLES = 250;
    localparam int  HOLD_CYCLES    = 3000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_command = CMD_SAMPLE;
    logic [15:0] i_sample = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [15:0] o_blurred_sample;
    logic        o_last_of_frame;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = CFG_RADIUS;
    logic [63:0] i_cfg_data = '0;

    int          fail_count, outstanding, predicted;
    int          cycle_count = 0;
    int          samples_sent = 0;
    int          hold_asked = 0;
    bit          no_gaps = 1'b0;

    // Register shadows, used only to size each frame.
    int unsigned radius_now = 0, width_now = 1024, height_now = 1024, chan_now = 1;
    logic [15:0] tap_set [16];

    separable_gaussian_blur_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_sample         (i_sample),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_blurred_sample (o_blurred_sample),
        .o_last_of_frame  (o_last_of_frame),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    separable_gaussian_blur_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_sample         (i_sample),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_blurred_sample (o_blurred_sample),
        .i_last_of_frame  (o_last_of_frame),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_outstanding    (outstanding),
        .o_predicted      (predicted)
    );

    always #4 i_clk = ~i_clk;

    // Hard stop in case the core hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("tb_separable_gaussian_blur_core: errors");
            $finish;
        end
    end

    // Output side. It stalls about a quarter of the time, never while the no-gap stretch
    // runs, and serves each long hold-off request by holding ready low.
    initial begin
        int hold_done;
        hold_done = 0;
        forever begin
            @(posedge i_clk);
            if (hold_asked != hold_done) begin
                hold_done = hold_asked;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_out_ready <= no_gaps ? 1'b1 : ($urandom_range(99) >= 24);
        end
    end

    function automatic int unsigned frame_beats();
        int unsigned w, h, c;
        w = (width_now == 0) ? 1 : (width_now > 1024 ? 1024 : width_now);
        h = (height_now == 0) ? 1 : height_now;
        c = (chan_now == 0) ? 1 : (chan_now > 4 ? 4 : chan_now);
        return w * h * c;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [63:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_RADIUS:   radius_now = data[2:0];
            CFG_WIDTH:    width_now  = data[10:0];
            CFG_HEIGHT:   height_now = data[12:0];
            CFG_CHANNELS: chan_now   = data[2:0];
            default: ;
        endcase
    endtask

    task automatic write_geometry(int unsigned r, int unsigned w, int unsigned h,
                                  int unsigned c);
        write_reg(CFG_RADIUS, r);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_CHANNELS, c);
    endtask

    task automatic write_taps();
        write_reg(CFG_TAPS0, {tap_set[3], tap_set[2], tap_set[1], tap_set[0]});
        write_reg(CFG_TAPS1, {tap_set[7], tap_set[6], tap_set[5], tap_set[4]});
        write_reg(CFG_TAPS2, {tap_set[11], tap_set[10], tap_set[9], tap_set[8]});
        write_reg(CFG_TAPS3, {tap_set[15], tap_set[14], tap_set[13], tap_set[12]});
    endtask

    // Mostly weights that keep the sum near unity, sometimes fully random ones.
    task automatic pick_taps(int unsigned r);
        bit wild;
        wild = ($urandom_range(3) == 0);
        foreach (tap_set[i]) begin
            if (wild)
                tap_set[i] = $urandom;
            else
                tap_set[i] = $urandom_range(2 * 32768 / (2 * r + 1));
        end
    endtask

    // One input beat. The ready seen at the falling edge decides whether the next rising
    // edge accepts it, so the payload changes only after a real handshake.
    task automatic send_beat(logic cmd, logic [15:0] smp);
        bit taken;
        if (!no_gaps && $urandom_range(99) < 24) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 24);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_sample   <= smp;
        do begin
            @(negedge i_clk);
            taken = i_in_valid && o_in_ready;
            @(posedge i_clk);
        end while (!taken);
        if (cmd == CMD_SAMPLE) samples_sent++;
    endtask

    task automatic stop_sending();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait for every expected beat, then for the core to finish a beat that frees nothing.
    task automatic wait_drained();
        while (outstanding != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Feeds a frame, or only its first part when count is short of the frame size. A full
    // frame is followed by drain beats (and samples past frame end, which act as drains)
    // until its last output has been released.
    task automatic feed_frame(int unsigned count, bit complete, int unsigned drain_pct);
        int start;
        start = predicted;
        for (int unsigned i = 0; i < count; i++) begin
            while ($urandom_range(99) < drain_pct) send_beat(!CMD_SAMPLE, $urandom);
            send_beat(CMD_SAMPLE, $urandom);
        end
        if (complete) begin
            while (predicted - start < int'(frame_beats())) send_beat($urandom, $urandom);
        end
        stop_sending();
        wait_drained();
    endtask

    task automatic feed_directed(logic [15:0] first, logic [15:0] second);
        send_beat(CMD_SAMPLE, first);
        send_beat(CMD_SAMPLE, second);
    endtask

    initial begin
        int unsigned r, w, h, c, n;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset taps are a pass-through. A drain beat on an empty core releases nothing.
        write_geometry(0, 3, 2, 1);
        send_beat(!CMD_SAMPLE, 16'hFFFF);
        feed_directed(16'h0000, 16'hFFFF);
        feed_directed(16'h0001, 16'h8000);
        feed_directed(16'h7FFF, 16'hFFFF);
        stop_sending();
        wait_drained();

        // Zero geometry values act as one; full-scale weights saturate both passes.
        foreach (tap_set[i]) tap_set[i] = 16'hFFFF;
        write_taps();
        write_geometry(1, 0, 0, 0);
        feed_directed(16'hFFFF, 16'h0000);
        stop_sending();
        wait_drained();

        // Lagging outputs at frame end, released by drains and by samples past the end.
        foreach (tap_set[i]) tap_set[i] = '0;
        tap_set[0] = 16'h2000; tap_set[1] = 16'h4000; tap_set[2] = 16'h4000;
        tap_set[3] = 16'h4000; tap_set[4] = 16'h2000;
        write_taps();
        write_geometry(2, 2, 2, 2);
        feed_frame(8, 1'b1, 0);

        // Widest radius on a tall frame, abandoned part way by a geometry write.
        pick_taps(7);
        write_taps();
        write_geometry(7, 1, 8191, 1);
        feed_frame(12, 1'b0, 0);

        // Width and channel counts beyond their maxima, and the zero-weight kernel.
        foreach (tap_set[i]) tap_set[i] = '0;
        write_taps();
        write_geometry(0, 2047, 1, 7);
        feed_frame(8, 1'b0, 0);
        pick_taps(0);
        write_taps();
        write_geometry(0, 1024, 1, 1);
        no_gaps = 1'b1;
        feed_frame(1024, 1'b1, 0);
        no_gaps = 1'b0;

        // Long output hold-off while the input keeps offering beats.
        write_geometry(0, 16, 4, 1);
        hold_asked++;
        feed_frame(64, 1'b1, 5);

        samples_sent = 0;
        while (samples_sent < RANDOM_SAMPLES) begin
            if ($urandom_range(9) < 6) begin
                r = $urandom_range(2);
                w = $urandom_range(1, 12);
                h = $urandom_range(1, 8);
                c = $urandom_range(1, 4);
            end else begin
                r = $urandom_range(3, 7);
                w = $urandom_range(1, 4);
                h = $urandom_range(1, 4);
                c = $urandom_range(1, 2);
            end
            if ($urandom_range(9) == 0) begin
                w = $urandom_range(16, 64);
                h = 1;
            end
            no_gaps = ($urandom_range(7) == 0);
            pick_taps(r);
            write_taps();
            write_geometry(r, w, h, c);
            n = frame_beats();
            if ($urandom_range(9) == 0)
                feed_frame($urandom_range(n - 1), 1'b0, 10);
            else
                feed_frame(n, 1'b1, 10);
        end
        no_gaps = 1'b0;

        wait_drained();
        repeat (800) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("tb_separable_gaussian_blur_core: clean");
        end else begin
            $display("tb_separable_gaussian_blur_core: errors");
        end
        $finish;
    end

endmodule
